/* rtl/eitp_pkg.sv */
package eitp_pkg;

  localparam logic [31:0] HOST_WORD   = 32'h486f_7374;
  localparam logic [7:0]  CR_BYTE     = 8'h0d;
  localparam logic [7:0]  LF_BYTE     = 8'h0a;
  localparam logic [7:0]  ETH_HDR_LEN = 8'd14;
  localparam logic [7:0]  TCP_OFF_BYTE = 8'd12;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;

  localparam int unsigned OUT_DATA_W = 224;

  // Host-line search progress within one frame
  typedef enum logic [1:0] {
    HP_SEARCH = 2'd0,
    HP_EMIT   = 2'd1,
    HP_DONE   = 2'd2
  } host_phase_t;

  // Frame classes reported in the summary
  typedef enum logic [1:0] {
    FC_OTHER = 2'd0,
    FC_IPV4  = 2'd1,
    FC_TCP   = 2'd2
  } frame_class_t;

  // Result kinds carried on the output tuser
  localparam logic KIND_HOST    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [15:0]  payload_len;
    frame_class_t frame_class;
    logic         host_found;
  } summary_t;

  // All results caused by one accepted byte: host_cnt host-line bytes
  // (0, 1, or 4 for the "Host" match) followed by an optional summary
  typedef struct packed {
    logic [2:0] host_cnt;
    logic [7:0] host_byte;
    logic       has_sum;
    summary_t   sum;
  } bundle_t;

endpackage

/* rtl/eitp_parser.sv */
module eitp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output eitp_pkg::bundle_t bundle
);
  import eitp_pkg::*;

  logic [15:0] pos_r,       pos_nxt;
  logic [47:0] dst_mac_r,   dst_mac_nxt;
  logic [47:0] src_mac_r,   src_mac_nxt;
  logic [15:0] etype_r,     etype_nxt;
  logic [3:0]  hdr_words_r, hdr_words_nxt;
  logic [7:0]  proto_r,     proto_nxt;
  logic [15:0] total_len_r, total_len_nxt;
  logic [31:0] src_ip_r,    src_ip_nxt;
  logic [31:0] dst_ip_r,    dst_ip_nxt;
  logic [15:0] src_port_r,  src_port_nxt;
  logic [15:0] dst_port_r,  dst_port_nxt;
  logic [3:0]  tcp_words_r, tcp_words_nxt;
  logic [23:0] window_r,    window_nxt;
  host_phase_t phase_r,     phase_nxt;
  logic        prev_cr_r,   prev_cr_nxt;

  logic [7:0]  tstart;
  logic [7:0]  pstart;
  logic [16:0] pend;
  logic [15:0] tcp_off;
  logic        is_tcp;
  logic        in_payload;
  logic [6:0]  hdr_len;
  frame_class_t cls;
  logic [2:0]  host_cnt;

  always_comb begin
    pos_nxt       = pos_r;
    dst_mac_nxt   = dst_mac_r;
    src_mac_nxt   = src_mac_r;
    etype_nxt     = etype_r;
    hdr_words_nxt = hdr_words_r;
    proto_nxt     = proto_r;
    total_len_nxt = total_len_r;
    src_ip_nxt    = src_ip_r;
    dst_ip_nxt    = dst_ip_r;
    src_port_nxt  = src_port_r;
    dst_port_nxt  = dst_port_r;
    tcp_words_nxt = tcp_words_r;
    window_nxt    = window_r;
    phase_nxt     = phase_r;
    prev_cr_nxt   = prev_cr_r;
    host_cnt      = 3'd0;

    // Fixed-place header fields, each byte into its own lane
    if (pos_r < 16'd6) begin
      dst_mac_nxt[{3'(3'd5 - pos_r[2:0]), 3'b000} +: 8] = data_byte;
    end else if (pos_r < 16'd12) begin
      src_mac_nxt[{3'(4'd11 - pos_r[3:0]), 3'b000} +: 8] = data_byte;
    end else if (pos_r < 16'd14) begin
      etype_nxt[{~pos_r[0], 3'b000} +: 8] = data_byte;
    end else if (pos_r == 16'd14) begin
      hdr_words_nxt = data_byte[3:0];
    end else if (pos_r == 16'd16 || pos_r == 16'd17) begin
      total_len_nxt[{~pos_r[0], 3'b000} +: 8] = data_byte;
    end else if (pos_r == 16'd23) begin
      proto_nxt = data_byte;
    end else if (pos_r >= 16'd26 && pos_r < 16'd30) begin
      src_ip_nxt[{2'(2'd1 - pos_r[1:0]), 3'b000} +: 8] = data_byte;
    end else if (pos_r >= 16'd30 && pos_r < 16'd34) begin
      dst_ip_nxt[{2'(2'd1 - pos_r[1:0]), 3'b000} +: 8] = data_byte;
    end

    // TCP header sits after the IP header, wherever IHL puts it
    tstart  = ETH_HDR_LEN + {2'b00, hdr_words_nxt, 2'b00};
    tcp_off = pos_r - {8'd0, tstart};
    if (pos_r >= {8'd0, tstart}) begin
      if (tcp_off < 16'd2) begin
        src_port_nxt[{~tcp_off[0], 3'b000} +: 8] = data_byte;
      end else if (tcp_off < 16'd4) begin
        dst_port_nxt[{~tcp_off[0], 3'b000} +: 8] = data_byte;
      end else if (tcp_off == {8'd0, TCP_OFF_BYTE}) begin
        tcp_words_nxt = data_byte[7:4];
      end
    end

    is_tcp = (pos_r > 16'd23) && (etype_nxt == ETYPE_IPV4) && (proto_nxt == PROTO_TCP);
    pstart = tstart + {2'b00, tcp_words_nxt, 2'b00};
    pend   = {9'd0, ETH_HDR_LEN} + {1'b0, total_len_nxt};
    in_payload = is_tcp
               && (pos_r > {8'd0, 8'(tstart + TCP_OFF_BYTE)})
               && (pos_r >= {8'd0, pstart})
               && ({1'b0, pos_r} < pend);

    if (in_payload) begin
      case (phase_r)
        HP_SEARCH: begin
          if (window_r == HOST_WORD[31:8] && data_byte == HOST_WORD[7:0]) begin
            host_cnt    = 3'd4;
            phase_nxt   = HP_EMIT;
            prev_cr_nxt = 1'b0;
          end
          window_nxt = {window_r[15:0], data_byte};
        end
        HP_EMIT: begin
          if (prev_cr_r && data_byte == LF_BYTE) begin
            phase_nxt = HP_DONE;
          end else begin
            host_cnt    = 3'd1;
            prev_cr_nxt = (data_byte == CR_BYTE);
          end
        end
        default: begin
        end
      endcase
    end

    if (pos_r != 16'hffff) begin
      pos_nxt = pos_r + 16'd1;
    end

    // Summary reflects the state after this byte
    if (etype_nxt == ETYPE_IPV4) begin
      cls = (proto_nxt == PROTO_TCP) ? FC_TCP : FC_IPV4;
    end else begin
      cls = FC_OTHER;
    end
    hdr_len = {1'b0, hdr_words_nxt, 2'b00} + {1'b0, tcp_words_nxt, 2'b00};

    bundle.host_cnt        = host_cnt;
    bundle.host_byte       = data_byte;
    bundle.has_sum         = last_byte;
    bundle.sum.dst_mac     = dst_mac_nxt;
    bundle.sum.src_mac     = src_mac_nxt;
    bundle.sum.src_ip      = (cls != FC_OTHER) ? src_ip_nxt : 32'd0;
    bundle.sum.dst_ip      = (cls != FC_OTHER) ? dst_ip_nxt : 32'd0;
    bundle.sum.src_port    = (cls == FC_TCP) ? src_port_nxt : 16'd0;
    bundle.sum.dst_port    = (cls == FC_TCP) ? dst_port_nxt : 16'd0;
    bundle.sum.payload_len = (cls == FC_TCP && total_len_nxt > {9'd0, hdr_len})
                           ? 16'(total_len_nxt - {9'd0, hdr_len}) : 16'd0;
    bundle.sum.frame_class = cls;
    bundle.sum.host_found  = (phase_nxt != HP_SEARCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r       <= '0;
      dst_mac_r   <= '0;
      src_mac_r   <= '0;
      etype_r     <= '0;
      hdr_words_r <= '0;
      proto_r     <= '0;
      total_len_r <= '0;
      src_ip_r    <= '0;
      dst_ip_r    <= '0;
      src_port_r  <= '0;
      dst_port_r  <= '0;
      tcp_words_r <= '0;
      window_r    <= '0;
      phase_r     <= HP_SEARCH;
      prev_cr_r   <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      dst_mac_r   <= dst_mac_nxt;
      src_mac_r   <= src_mac_nxt;
      etype_r     <= etype_nxt;
      hdr_words_r <= hdr_words_nxt;
      proto_r     <= proto_nxt;
      total_len_r <= total_len_nxt;
      src_ip_r    <= src_ip_nxt;
      dst_ip_r    <= dst_ip_nxt;
      src_port_r  <= src_port_nxt;
      dst_port_r  <= dst_port_nxt;
      tcp_words_r <= tcp_words_nxt;
      window_r    <= window_nxt;
      phase_r     <= phase_nxt;
      prev_cr_r   <= prev_cr_nxt;
    end
  end

endmodule

/* rtl/eth_ipv4_tcp_header_parser_top.sv */
// Ethernet / IPv4 / TCP header parser with Host-line extraction.
// Input stream: one frame byte per transaction, in wire order, tlast on the
// final byte of the frame. Output stream: host-line byte transactions
// (tuser 0) for the Host line found in the TCP payload, and one summary
// transaction (tuser 1) per frame carrying MACs, IPs, ports, payload length,
// frame class and a host-found flag. tlast marks the final transaction
// caused by one input byte.
// Throughput: one byte per cycle while each byte causes at most one result
// and the receiver does not stall. The byte that completes "Host" causes four
// results, and a final byte adds the summary, so such a byte occupies the
// output for up to five results; the sequencer presents one result per cycle
// while out_tready is high. Parsing state is advanced in the accept cycle;
// the results of each byte land in an output slot, with one spare slot behind
// it, so input is still taken while a result waits. in_tready is a register:
// it drops when both slots are held, behind a stalled receiver or a
// multi-result byte.
// Reset: all parsing state is cleared, both slots are emptied; the parser
// also clears itself after the final byte of each frame.
module eth_ipv4_tcp_header_parser_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,  // data_byte
  input  logic                                 in_tlast,  // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // host_byte, dst_mac, src_mac, src_ip, dst_ip, src_port, dst_port,
  // payload_len, frame_class, host_found, zero fill
  output logic [eitp_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tuser, // result_kind
  output logic                                 out_tlast  // last_of_run
);
  import eitp_pkg::*;

  logic    in_accept;
  bundle_t new_bundle;
  logic    new_valid;

  bundle_t ob_r;
  logic    ob_valid_r;
  logic [2:0] idx_r;
  bundle_t sb_r;
  logic    sb_valid_r;

  logic [2:0] total;
  logic    ob_last;
  logic    out_fire;
  logic    ob_free;
  logic    is_sum;
  logic [7:0] cur_byte;

  assign in_tready = !sb_valid_r;
  assign in_accept = in_tvalid && in_tready;

  eitp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .bundle    (new_bundle)
  );

  // Drop bytes that cause no result
  assign new_valid = in_accept && (new_bundle.host_cnt != 3'd0 || new_bundle.has_sum);

  assign total    = ob_r.host_cnt + {2'b00, ob_r.has_sum};
  assign ob_last  = (idx_r == 3'(total - 3'd1));
  assign out_fire = ob_valid_r && out_tready;
  assign ob_free  = !ob_valid_r || (out_fire && ob_last);

  // Slot control: refill the output slot from the spare first to keep order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (ob_free) begin
      idx_r <= '0;
      if (sb_valid_r) begin
        ob_r       <= sb_r;
        ob_valid_r <= 1'b1;
        sb_r       <= new_bundle;
        sb_valid_r <= new_valid;
      end else begin
        ob_r       <= new_bundle;
        ob_valid_r <= new_valid;
      end
    end else begin
      if (out_fire) begin
        idx_r <= idx_r + 3'd1;
      end
      if (new_valid) begin
        sb_r       <= new_bundle;
        sb_valid_r <= 1'b1;
      end
    end
  end

  // Present the current result of the output slot
  always_comb begin
    is_sum = (idx_r >= ob_r.host_cnt);
    if (ob_r.host_cnt == 3'd4) begin
      cur_byte = HOST_WORD[{2'(2'd3 - idx_r[1:0]), 3'b000} +: 8];
    end else begin
      cur_byte = ob_r.host_byte;
    end

    out_tdata = '0;
    if (is_sum) begin
      out_tdata[55:8]    = ob_r.sum.dst_mac;
      out_tdata[103:56]  = ob_r.sum.src_mac;
      out_tdata[135:104] = ob_r.sum.src_ip;
      out_tdata[167:136] = ob_r.sum.dst_ip;
      out_tdata[183:168] = ob_r.sum.src_port;
      out_tdata[199:184] = ob_r.sum.dst_port;
      out_tdata[215:200] = ob_r.sum.payload_len;
      out_tdata[217:216] = ob_r.sum.frame_class;
      out_tdata[218]     = ob_r.sum.host_found;
    end else begin
      out_tdata[7:0] = cur_byte;
    end
    out_tuser  = is_sum ? KIND_SUMMARY : KIND_HOST;
    out_tlast  = ob_last;
    out_tvalid = ob_valid_r;
  end

endmodule

/* test/tb_eth_ipv4_tcp_header_parser_top.sv */
module tb_eth_ipv4_tcp_header_parser_top;
  import eitp_pkg::*;

  // Output tdata as the block packs it, lowest field in the lowest bits
  typedef struct packed {
    logic [4:0]   fill;
    logic         host_found;
    frame_class_t frame_class;
    logic [15:0]  payload_len;
    logic [15:0]  dst_port;
    logic [15:0]  src_port;
    logic [31:0]  dst_ip;
    logic [31:0]  src_ip;
    logic [47:0]  src_mac;
    logic [47:0]  dst_mac;
    logic [7:0]   host_byte;
  } out_word_t;

  // One expected output transaction: kind on tuser, end of run on tlast
  typedef struct packed {
    logic      kind;
    logic      last;
    out_word_t w;
  } parse_result_t;

  localparam int IDLE_LIMIT = 3000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  eth_ipv4_tcp_header_parser_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Parser state as the predictor sees it, cleared at reset and after each frame
  logic [15:0]  ps_pos;
  logic [47:0]  ps_dst_mac;
  logic [47:0]  ps_src_mac;
  logic [15:0]  ps_etype;
  logic [3:0]   ps_ihl;
  logic [7:0]   ps_proto;
  logic [15:0]  ps_tot_len;
  logic [31:0]  ps_src_ip;
  logic [31:0]  ps_dst_ip;
  logic [15:0]  ps_src_port;
  logic [15:0]  ps_dst_port;
  logic [3:0]   ps_doff;
  logic [23:0]  ps_window;
  host_phase_t  ps_phase;
  logic         ps_prev_cr;

  parse_result_t expected_results[$];
  logic [7:0]    frame_buf[$];
  logic [7:0]    payload_buf[$];

  int  mismatches;
  int  sent_bytes;
  int  results_predicted;
  int  idle_cycles;
  int  rx_stall_left;
  bit  tx_gaps;
  bit  rx_gaps;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Header sizes in 32-bit words: mostly short, so frames stay small
  function automatic int pick_hdr_words();
    if ($urandom_range(0, 9) == 0) return $urandom_range(6, 15);
    return $urandom_range(0, 5);
  endfunction

  function automatic parse_result_t host_item(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    r.kind = KIND_HOST;
    r.w.host_byte = b;
    return r;
  endfunction

  task automatic clear_parser_state();
    ps_pos = '0;      ps_dst_mac = '0;  ps_src_mac = '0;  ps_etype = '0;
    ps_ihl = '0;      ps_proto = '0;    ps_tot_len = '0;  ps_src_ip = '0;
    ps_dst_ip = '0;   ps_src_port = '0; ps_dst_port = '0; ps_doff = '0;
    ps_window = '0;   ps_phase = HP_SEARCH;  ps_prev_cr = 1'b0;
  endtask

  // Advance the parser by one accepted byte and queue every result it causes
  task automatic parse_frame_byte(input logic [7:0] b, input logic last);
    int p;
    int tstart;
    int pstart;
    int pend;
    int hl;
    bit is_tcp;
    bit in_payload;
    frame_class_t cls;
    parse_result_t r;
    parse_result_t run[$];
    p = int'(ps_pos);

    // Fixed header fields, OR-ed in at their own byte place
    if (p < 6) ps_dst_mac |= 48'(b) << (8 * (5 - p));
    else if (p < 12) ps_src_mac |= 48'(b) << (8 * (11 - p));
    else if (p < 14) ps_etype |= 16'(b) << (8 * (13 - p));
    else if (p == 14) ps_ihl = b[3:0];
    else if (p == 16 || p == 17) ps_tot_len |= 16'(b) << (8 * (17 - p));
    else if (p == 23) ps_proto = b;
    else if (p >= 26 && p < 30) ps_src_ip |= 32'(b) << (8 * (29 - p));
    else if (p >= 30 && p < 34) ps_dst_ip |= 32'(b) << (8 * (33 - p));

    if (p >= int'(ETH_HDR_LEN)) begin
      // TCP header sits after IHL words, even when that overlaps the IP header
      tstart = int'(ETH_HDR_LEN) + 4 * int'(ps_ihl);
      if (p >= tstart && p < tstart + 2)
        ps_src_port |= 16'(b) << (8 * (tstart + 1 - p));
      else if (p >= tstart + 2 && p < tstart + 4)
        ps_dst_port |= 16'(b) << (8 * (tstart + 3 - p));
      else if (p == tstart + int'(TCP_OFF_BYTE))
        ps_doff = b[7:4];

      is_tcp = p > 23 && ps_etype == ETYPE_IPV4 && ps_proto == PROTO_TCP;
      pstart = tstart + 4 * int'(ps_doff);
      pend = int'(ETH_HDR_LEN) + int'(ps_tot_len);
      in_payload = is_tcp && p > tstart + int'(TCP_OFF_BYTE) && p >= pstart && p < pend;

      if (in_payload) begin
        if (ps_phase == HP_SEARCH) begin
          if ({ps_window, b} == HOST_WORD) begin
            run.push_back(host_item(HOST_WORD[31:24]));
            run.push_back(host_item(HOST_WORD[23:16]));
            run.push_back(host_item(HOST_WORD[15:8]));
            run.push_back(host_item(HOST_WORD[7:0]));
            ps_phase = HP_EMIT;
            ps_prev_cr = 1'b0;
          end
          ps_window = {ps_window[15:0], b};
        end else if (ps_phase == HP_EMIT) begin
          if (ps_prev_cr && b == LF_BYTE) begin
            ps_phase = HP_DONE;
          end else begin
            run.push_back(host_item(b));
            ps_prev_cr = (b == CR_BYTE);
          end
        end
      end
    end

    if (ps_pos != 16'hFFFF) ps_pos = ps_pos + 16'd1;

    if (last) begin
      cls = FC_OTHER;
      if (ps_etype == ETYPE_IPV4) cls = (ps_proto == PROTO_TCP) ? FC_TCP : FC_IPV4;
      r = '0;
      r.kind = KIND_SUMMARY;
      r.w.dst_mac = ps_dst_mac;
      r.w.src_mac = ps_src_mac;
      if (cls != FC_OTHER) begin
        r.w.src_ip = ps_src_ip;
        r.w.dst_ip = ps_dst_ip;
      end
      if (cls == FC_TCP) begin
        hl = 4 * int'(ps_ihl) + 4 * int'(ps_doff);
        r.w.src_port = ps_src_port;
        r.w.dst_port = ps_dst_port;
        r.w.payload_len = (int'(ps_tot_len) > hl) ? 16'(int'(ps_tot_len) - hl) : 16'd0;
      end
      r.w.frame_class = cls;
      r.w.host_found = (ps_phase != HP_SEARCH);
      run.push_back(r);
      clear_parser_state();
    end

    // Mark the final result of this byte, then hand the run over in order
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_results.push_back(run[i]);
    results_predicted += run.size();
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 40)
      $display("mismatch on %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Offer one byte on the input stream, with an optional gap before it,
  // and predict its results once the transaction is taken
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
    parse_frame_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) payload_buf.push_back(s[i]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) payload_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Lay out a frame around payload_buf: random filler, the IPv4 fields the
  // parser reads, the TCP data offset, then the payload. len_skew moves the
  // IP total length away from the true payload end; pad adds filler after
  // the payload, or cuts the frame short when negative.
  task automatic build_frame(input int ihl, input int doff, input logic [15:0] etype,
                             input logic [7:0] proto, input int len_skew, input int pad);
    int tstart;
    int pstart;
    int tot;
    int flen;
    tstart = 14 + 4 * ihl;
    pstart = tstart + 4 * doff;
    if (pstart < tstart + 13) pstart = tstart + 13;
    tot = pstart + payload_buf.size() - 14 + len_skew;
    if (tot < 0) tot = 0;
    if (tot > 65535) tot = 65535;
    flen = pstart + payload_buf.size() + pad;
    if (flen < 1) flen = 1;
    frame_buf.delete();
    repeat (pstart + payload_buf.size())
      frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf[12] = etype[15:8];
    frame_buf[13] = etype[7:0];
    frame_buf[14] = {4'h4, 4'(ihl)};
    frame_buf[16] = 8'(tot >> 8);
    frame_buf[17] = 8'(tot);
    frame_buf[23] = proto;
    frame_buf[tstart + 12] = {4'(doff), 4'h0};
    foreach (payload_buf[i]) frame_buf[pstart + i] = payload_buf[i];
    while (frame_buf.size() > flen) void'(frame_buf.pop_back());
    while (frame_buf.size() < flen) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Frames shorter than the headers: missing fields must read as zero
  task automatic test_runt_frames();
    frame_buf = '{8'hFF};
    send_frame();
    frame_buf = '{8'h00};
    send_frame();
    frame_buf.delete();
    repeat (13) frame_buf.push_back(8'hFF);
    send_frame();
  endtask

  // A Host line outside IPv4, and inside IPv4 that is not TCP, is not searched
  task automatic test_other_protocols();
    payload_buf.delete();
    add_text("Host\r\n");
    build_frame(5, 5, 16'h86DD, PROTO_TCP, 0, 0);
    send_frame();
    build_frame(5, 2, ETYPE_IPV4, 8'd17, 0, 2);
    send_frame();
  endtask

  task automatic test_host_line();
    payload_buf.delete();
    add_text("GET / HTTP/1.1\r\nHost: a\r\n\r\n");
    build_frame(5, 5, ETYPE_IPV4, PROTO_TCP, 0, 4);
    send_frame();
  endtask

  // "Host" completed by the final byte: four host bytes plus the summary
  task automatic test_host_on_last_byte();
    payload_buf.delete();
    add_text("xHost");
    build_frame(0, 0, ETYPE_IPV4, PROTO_TCP, 0, 0);
    send_frame();
  endtask

  // Total length ends the payload early; then headers longer than the total
  task automatic test_length_clamp();
    payload_buf.delete();
    add_text("abHost:x\r\n");
    build_frame(2, 3, ETYPE_IPV4, PROTO_TCP, -8, 0);
    send_frame();
    payload_buf.delete();
    add_text("Host\r\n");
    build_frame(6, 6, ETYPE_IPV4, PROTO_TCP, -40, 0);
    send_frame();
  endtask

  // Payload claimed past the frame end: emission stops at the final byte
  task automatic test_payload_past_frame();
    payload_buf.delete();
    add_text("Host: q");
    build_frame(1, 4, ETYPE_IPV4, PROTO_TCP, 20, 0);
    send_frame();
  endtask

  task automatic test_header_extremes();
    payload_buf.delete();
    add_text("Host\r\n");
    build_frame(15, 15, ETYPE_IPV4, PROTO_TCP, 0, 1);
    send_frame();
    build_frame(15, 0, ETYPE_IPV4, PROTO_TCP, 0, 0);
    send_frame();
  endtask

  // Frame past 64 KiB: the position counter saturates and the tail of the
  // Host match lands at the saturated position
  task automatic test_long_frame();
    payload_buf.delete();
    repeat (65540 - 27 - 7) payload_buf.push_back(8'h00);
    add_text("Host:zz");
    build_frame(0, 0, ETYPE_IPV4, PROTO_TCP, 65535, 0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_frame();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_results;
    int kind;
    int skew;
    bit drained;
    start_bytes = sent_bytes;
    start_results = results_predicted;
    drained = 1'b0;
    while ((sent_bytes - start_bytes) < 160 || (results_predicted - start_results) < 48) begin
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      // Hold the sender once, midway, until the output has fully drained
      if (!drained && (sent_bytes - start_bytes) >= 80) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        drained = 1'b1;
      end

      payload_buf.delete();
      add_noise($urandom_range(0, 6));
      case ($urandom_range(0, 6))
        0: ;
        1: begin add_text("Host: "); add_noise($urandom_range(0, 4)); add_text("\r\n"); end
        2: add_text("Host\rx\r\n");
        3: add_text("HHosHost\r\n");
        4: add_text("Host:");
        5: add_text("Host\r\r\n");
        default: add_text("Hostx\r\nHost\r\n");
      endcase
      add_noise($urandom_range(0, 4));

      case ($urandom_range(0, 7))
        0, 1, 2, 3, 4: skew = 0;
        5: skew = -$urandom_range(1, 6);
        6: skew = $urandom_range(1, 10);
        default: skew = -$urandom_range(20, 80);
      endcase

      kind = $urandom_range(0, 9);
      case (kind)
        6: build_frame(pick_hdr_words(), pick_hdr_words(), ETYPE_IPV4,
                       8'($urandom_range(0, 255)), skew, $urandom_range(0, 3));
        7: build_frame(pick_hdr_words(), pick_hdr_words(), 16'($urandom_range(0, 65535)),
                       PROTO_TCP, skew, $urandom_range(0, 3));
        8: begin
          // Noise frame, sometimes carrying the IPv4 ethertype
          frame_buf.delete();
          repeat ($urandom_range(1, 24)) frame_buf.push_back(8'($urandom_range(0, 255)));
          if (frame_buf.size() > 13 && $urandom_range(0, 1)) begin
            frame_buf[12] = ETYPE_IPV4[15:8];
            frame_buf[13] = ETYPE_IPV4[7:0];
          end
        end
        9: build_frame(pick_hdr_words(), pick_hdr_words(), ETYPE_IPV4, PROTO_TCP,
                       skew, -$urandom_range(1, 40));
        default: build_frame(pick_hdr_words(), pick_hdr_words(), ETYPE_IPV4, PROTO_TCP,
                             skew, $urandom_range(0, 3));
      endcase
      send_frame();
    end
  endtask

  // Receiver: drive tready at the falling edge, stalling in runs of random length
  initial begin
    out_tready = 1'b0;
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_stall_left > 0) begin
        out_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_gaps && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
      end
    end
  end

  // Check every accepted output transaction against the oldest expectation
  always @(posedge clk) begin : check_out
    parse_result_t want;
    out_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_word_t'(out_tdata);
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing expected", out_tdata[63:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser != want.kind) flag_mismatch("result_kind", 64'(out_tuser), 64'(want.kind));
        if (out_tlast != want.last) flag_mismatch("last_of_run", 64'(out_tlast), 64'(want.last));
        if (got.host_byte != want.w.host_byte)
          flag_mismatch("host_byte", 64'(got.host_byte), 64'(want.w.host_byte));
        if (got.dst_mac != want.w.dst_mac)
          flag_mismatch("dst_mac", 64'(got.dst_mac), 64'(want.w.dst_mac));
        if (got.src_mac != want.w.src_mac)
          flag_mismatch("src_mac", 64'(got.src_mac), 64'(want.w.src_mac));
        if (got.src_ip != want.w.src_ip)
          flag_mismatch("src_ip", 64'(got.src_ip), 64'(want.w.src_ip));
        if (got.dst_ip != want.w.dst_ip)
          flag_mismatch("dst_ip", 64'(got.dst_ip), 64'(want.w.dst_ip));
        if (got.src_port != want.w.src_port)
          flag_mismatch("src_port", 64'(got.src_port), 64'(want.w.src_port));
        if (got.dst_port != want.w.dst_port)
          flag_mismatch("dst_port", 64'(got.dst_port), 64'(want.w.dst_port));
        if (got.payload_len != want.w.payload_len)
          flag_mismatch("payload_len", 64'(got.payload_len), 64'(want.w.payload_len));
        if (got.frame_class != want.w.frame_class)
          flag_mismatch("frame_class", 64'(got.frame_class), 64'(want.w.frame_class));
        if (got.host_found != want.w.host_found)
          flag_mismatch("host_found", 64'(got.host_found), 64'(want.w.host_found));
        if (got.fill != '0) flag_mismatch("zero fill", 64'(got.fill), '0);
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    mismatches = 0;
    sent_bytes = 0;
    results_predicted = 0;
    idle_cycles = 0;
    clear_parser_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames first, plain handshakes, then with gaps on both sides
    test_runt_frames();
    test_other_protocols();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_host_line();
    test_host_on_last_byte();
    test_length_clamp();
    test_payload_past_frame();
    test_header_extremes();
    test_long_frame();
    test_random_traffic();

    // Drop valid, drain every expected result, then allow a short tail
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
